FILE: hw/rtl/vwrgb_pkg.sv
`default_nettype none

package vwrgb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int Q_W        = 64;
    localparam int SHIFT_W    = $clog2(Q_W);
    localparam int SH_W       = 13;
    localparam int N_W        = Q_W + 9;
    localparam int DIV_STAGES = 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [Q_W-1:0] SIGN_BIT = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [7:0]     GRAY_MAX = 8'd255;
    localparam logic [Q_W-1:0] WIN_MAX_RST =
        {{(Q_W-8-FRAC_BITS){1'b0}}, GRAY_MAX, {FRAC_BITS{1'b0}}};

    // element types
    localparam logic [3:0] ET_U8     = 4'd0;
    localparam logic [3:0] ET_S8     = 4'd1;
    localparam logic [3:0] ET_U16    = 4'd2;
    localparam logic [3:0] ET_S16    = 4'd3;
    localparam logic [3:0] ET_U32    = 4'd4;
    localparam logic [3:0] ET_S32    = 4'd5;
    localparam logic [3:0] ET_U64    = 4'd6;
    localparam logic [3:0] ET_S64    = 4'd7;
    localparam logic [3:0] ET_F32    = 4'd8;
    localparam logic [3:0] ET_F64    = 4'd9;
    localparam logic [3:0] ET_RGB24  = 4'd10;
    localparam logic [3:0] ET_RGBA32 = 4'd11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANAR_COLOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_CHANNEL = 3'd4;

    // color channels
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // shift amounts for the fixed point conversion
    localparam logic [SH_W-1:0] SH_INT     = SH_W'(FRAC_BITS);
    localparam logic [SH_W-1:0] SH_SAT     = SH_W'(200);
    localparam logic [SH_W-1:0] SH_F32_OFS = SH_W'(150 - FRAC_BITS);
    localparam logic [SH_W-1:0] SH_F32_SUB = SH_W'(1 - 150 + FRAC_BITS);
    localparam logic [SH_W-1:0] SH_F64_OFS = SH_W'(1075 - FRAC_BITS);
    localparam logic [SH_W-1:0] SH_F64_SUB = SH_W'(1 - 1075 + FRAC_BITS);

    typedef struct packed {
        logic [63:0] raw_element;
        logic        end_of_slice;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_byte;
        logic [7:0] green_byte;
        logic [7:0] blue_byte;
        logic [2:0] channel_valid;
        logic       type_error;
        logic       slice_done;
    } out_item_t;

    typedef struct packed {
        logic [3:0]     element_type;
        logic           planar_color;
        logic [1:0]     plane_channel;
        logic [Q_W-1:0] bmin;
        logic [Q_W-1:0] span;
        logic           inverted;
        logic           empty;
    } cfg_t;

    typedef struct packed {
        logic       eos;
        logic       err;
        logic       bypass;
        logic       is_rgb;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } meta_t;

    typedef struct packed {
        logic zero;
        logic full;
    } map_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vwrgb_cfg.sv
`default_nettype none

module vwrgb_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vwrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vwrgb_pkg::Q_W-1:0]        cfg_data,
    output vwrgb_pkg::cfg_t                  cfg,
    output logic                             busy
);
    import vwrgb_pkg::*;

    logic [3:0]     element_type_reg, element_type_next;
    logic [Q_W-1:0] window_min_reg, window_min_next;
    logic [Q_W-1:0] window_max_reg, window_max_next;
    logic           planar_color_reg, planar_color_next;
    logic [1:0]     plane_channel_reg, plane_channel_next;
    logic           pending_reg, pending_next;

    logic [Q_W-1:0] bmin_reg, bmin_next;
    logic [Q_W-1:0] span_reg, span_next;
    logic           inverted_reg, inverted_next;
    logic           empty_reg, empty_next;

    logic [Q_W-1:0] bmax;
    logic [Q_W:0]   up_diff;
    logic [Q_W:0]   dn_diff;
    logic           wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_comb
    begin
        element_type_next  = element_type_reg;
        window_min_next    = window_min_reg;
        window_max_next    = window_max_reg;
        planar_color_next  = planar_color_reg;
        plane_channel_next = plane_channel_reg;
        pending_next       = 1'b0;
        if (wr)
        begin
            case (cfg_index)
                REG_ELEMENT_TYPE:  element_type_next = cfg_data[3:0];
                REG_WINDOW_MIN:
                begin
                    window_min_next = cfg_data;
                    pending_next    = 1'b1;
                end
                REG_WINDOW_MAX:
                begin
                    window_max_next = cfg_data;
                    pending_next    = 1'b1;
                end
                REG_PLANAR_COLOR:  planar_color_next = cfg_data[0];
                REG_PLANE_CHANNEL: plane_channel_next = cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // window bounds in offset binary so that unsigned compares order them
    always_comb
    begin
        bmin_next     = window_min_reg ^ SIGN_BIT;
        bmax          = window_max_reg ^ SIGN_BIT;
        up_diff       = {1'b0, bmax} - {1'b0, bmin_next};
        dn_diff       = {1'b0, bmin_next} - {1'b0, bmax};
        inverted_next = up_diff[Q_W];
        empty_next    = (up_diff[Q_W-1:0] == '0);
        span_next     = up_diff[Q_W] ? dn_diff[Q_W-1:0] : up_diff[Q_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_type_reg  <= ET_U8;
            window_min_reg    <= '0;
            window_max_reg    <= WIN_MAX_RST;
            planar_color_reg  <= 1'b0;
            plane_channel_reg <= CH_RED;
            pending_reg       <= 1'b1;
        end
        else
        begin
            element_type_reg  <= element_type_next;
            window_min_reg    <= window_min_next;
            window_max_reg    <= window_max_next;
            planar_color_reg  <= planar_color_next;
            plane_channel_reg <= plane_channel_next;
            pending_reg       <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bmin_reg     <= bmin_next;
        span_reg     <= span_next;
        inverted_reg <= inverted_next;
        empty_reg    <= empty_next;
    end

    // hold off new voxels while the window span settles
    assign busy = pending_reg;

    always_comb
    begin
        cfg.element_type  = element_type_reg;
        cfg.planar_color  = planar_color_reg;
        cfg.plane_channel = plane_channel_reg;
        cfg.bmin          = bmin_reg;
        cfg.span          = span_reg;
        cfg.inverted      = inverted_reg;
        cfg.empty         = empty_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vwrgb_conv.sv
`default_nettype none

module vwrgb_conv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  vwrgb_pkg::in_item_t        in_item,
    input  vwrgb_pkg::cfg_t            cfg,
    output logic                       out_valid,
    output logic [vwrgb_pkg::Q_W-1:0]  out_value,
    output vwrgb_pkg::meta_t           out_meta
);
    import vwrgb_pkg::*;

    // decode stage
    logic [Q_W-1:0]  raw;
    logic [Q_W-1:0]  sx;
    logic            take_signed;
    logic            neg_next;
    logic [Q_W-1:0]  mag_next;
    logic [SH_W-1:0] sh_next;
    meta_t           meta_next;

    logic            p1_valid_reg;
    logic            p1_neg_reg;
    logic [Q_W-1:0]  p1_mag_reg;
    logic [SH_W-1:0] p1_sh_reg;
    meta_t           p1_meta_reg;

    // shift stage
    logic [Q_W-1:0]  q_next;
    logic            sat_next;
    logic [Q_W-1:0]  t;
    logic [SH_W-1:0] rm1;

    logic            p2_valid_reg;
    logic            p2_neg_reg;
    logic [Q_W-1:0]  p2_q_reg;
    logic            p2_sat_reg;
    meta_t           p2_meta_reg;

    // sign stage
    logic            sat_all;
    logic [Q_W-1:0]  bv_next;

    logic            p3_valid_reg;
    logic [Q_W-1:0]  p3_bv_reg;
    meta_t           p3_meta_reg;

    assign raw = in_item.raw_element;

    always_comb
    begin
        sx             = '0;
        take_signed    = 1'b0;
        neg_next       = 1'b0;
        mag_next       = '0;
        sh_next        = SH_INT;
        meta_next.eos    = in_item.end_of_slice;
        meta_next.err    = 1'b0;
        meta_next.bypass = 1'b0;
        meta_next.is_rgb = 1'b0;
        meta_next.b0     = raw[7:0];
        meta_next.b1     = raw[15:8];
        meta_next.b2     = raw[23:16];
        case (cfg.element_type)
            ET_U8:  meta_next.bypass = 1'b1;
            ET_S8:
            begin
                take_signed = 1'b1;
                sx = {{(Q_W-8){raw[7]}}, raw[7:0]};
            end
            ET_U16: mag_next = {{(Q_W-16){1'b0}}, raw[15:0]};
            ET_S16:
            begin
                take_signed = 1'b1;
                sx = {{(Q_W-16){raw[15]}}, raw[15:0]};
            end
            ET_U32: mag_next = {{(Q_W-32){1'b0}}, raw[31:0]};
            ET_S32:
            begin
                take_signed = 1'b1;
                sx = {{(Q_W-32){raw[31]}}, raw[31:0]};
            end
            ET_U64: mag_next = raw;
            ET_S64:
            begin
                take_signed = 1'b1;
                sx = raw;
            end
            ET_F32:
            begin
                neg_next = raw[31];
                if (raw[30:23] == 8'hFF)
                begin
                    // NaN reads as zero, infinity saturates by its sign
                    if (raw[22:0] != 23'h0)
                    begin
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        mag_next = Q_W'(1);
                        sh_next  = SH_SAT;
                    end
                end
                else if (raw[30:23] == 8'h00)
                begin
                    mag_next = Q_W'(raw[22:0]);
                    sh_next  = SH_F32_SUB;
                end
                else
                begin
                    mag_next = Q_W'({1'b1, raw[22:0]});
                    sh_next  = SH_W'(raw[30:23]) - SH_F32_OFS;
                end
            end
            ET_F64:
            begin
                neg_next = raw[63];
                if (raw[62:52] == 11'h7FF)
                begin
                    if (raw[51:0] != 52'h0)
                    begin
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        mag_next = Q_W'(1);
                        sh_next  = SH_SAT;
                    end
                end
                else if (raw[62:52] == 11'h000)
                begin
                    mag_next = Q_W'(raw[51:0]);
                    sh_next  = SH_F64_SUB;
                end
                else
                begin
                    mag_next = Q_W'({1'b1, raw[51:0]});
                    sh_next  = SH_W'(raw[62:52]) - SH_F64_OFS;
                end
            end
            ET_RGB24, ET_RGBA32:
            begin
                meta_next.bypass = 1'b1;
                meta_next.is_rgb = 1'b1;
            end
            default: meta_next.err = 1'b1;
        endcase
        if (take_signed)
        begin
            neg_next = sx[Q_W-1];
            mag_next = sx[Q_W-1] ? (~sx + Q_W'(1)) : sx;
        end
    end

    // magnitude times 2^sh, rounded half up on right shifts
    always_comb
    begin
        q_next   = '0;
        sat_next = 1'b0;
        t        = '0;
        rm1      = ~p1_sh_reg;
        if (!p1_sh_reg[SH_W-1])
        begin
            if (p1_sh_reg[SH_W-2:SHIFT_W] != '0)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                q_next   = p1_mag_reg << p1_sh_reg[SHIFT_W-1:0];
                sat_next = (p1_mag_reg >> (~p1_sh_reg[SHIFT_W-1:0])) != '0;
            end
        end
        else if (rm1[SH_W-1:SHIFT_W] == '0)
        begin
            t      = p1_mag_reg >> rm1[SHIFT_W-1:0];
            q_next = (t >> 1) + Q_W'(t[0]);
        end
        if (p1_mag_reg == '0)
        begin
            q_next   = '0;
            sat_next = 1'b0;
        end
    end

    // apply sign, saturate, move to offset binary
    always_comb
    begin
        sat_all = p2_sat_reg
                | (!p2_neg_reg & p2_q_reg[Q_W-1])
                | (p2_neg_reg & p2_q_reg[Q_W-1] & (p2_q_reg[Q_W-2:0] != '0));
        if (sat_all)
        begin
            bv_next = p2_neg_reg ? '0 : '1;
        end
        else
        begin
            bv_next = (p2_neg_reg ? (~p2_q_reg + Q_W'(1)) : p2_q_reg) ^ SIGN_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_neg_reg  <= neg_next;
        p1_mag_reg  <= mag_next;
        p1_sh_reg   <= sh_next;
        p1_meta_reg <= meta_next;
        p2_neg_reg  <= p1_neg_reg;
        p2_q_reg    <= q_next;
        p2_sat_reg  <= sat_next;
        p2_meta_reg <= p1_meta_reg;
        p3_bv_reg   <= bv_next;
        p3_meta_reg <= p2_meta_reg;
    end

    assign out_valid = p3_valid_reg;
    assign out_value = p3_bv_reg;
    assign out_meta  = p3_meta_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vwrgb_win.sv
`default_nettype none

module vwrgb_win (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [vwrgb_pkg::Q_W-1:0]  in_value,
    input  vwrgb_pkg::meta_t           in_meta,
    input  vwrgb_pkg::cfg_t            cfg,
    output logic                       out_valid,
    output logic [vwrgb_pkg::N_W-1:0]  out_num,
    output vwrgb_pkg::meta_t           out_meta,
    output vwrgb_pkg::map_flags_t      out_flags
);
    import vwrgb_pkg::*;

    logic [Q_W:0]   dpos;
    logic [Q_W:0]   dneg;
    logic           zero_next;
    logic [Q_W-1:0] a_next;

    logic           p4_valid_reg;
    logic [Q_W-1:0] p4_a_reg;
    logic           p4_zero_reg;
    meta_t          p4_meta_reg;

    logic [N_W-1:0] m510_next;

    logic           p5_valid_reg;
    logic [N_W-1:0] p5_m510_reg;
    map_flags_t     p5_flags_reg;
    meta_t          p5_meta_reg;

    logic           p6_valid_reg;
    logic [N_W-1:0] p6_num_reg;
    map_flags_t     p6_flags_reg;
    meta_t          p6_meta_reg;

    // distance from the window edge that maps to zero
    always_comb
    begin
        dpos = {1'b0, in_value} - {1'b0, cfg.bmin};
        dneg = {1'b0, cfg.bmin} - {1'b0, in_value};
        if (cfg.inverted)
        begin
            zero_next = !dpos[Q_W];
            a_next    = dneg[Q_W-1:0];
        end
        else
        begin
            zero_next = !dneg[Q_W];
            a_next    = dpos[Q_W-1:0];
        end
        zero_next = zero_next | cfg.empty;
    end

    // 510*a, so that round(255*a/b) = floor((510*a + b) / (2*b))
    assign m510_next = {p4_a_reg, 9'b0} - {8'b0, p4_a_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
        end
        else
        begin
            p4_valid_reg <= in_valid;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p4_a_reg          <= a_next;
        p4_zero_reg       <= zero_next;
        p4_meta_reg       <= in_meta;
        p5_m510_reg       <= m510_next;
        p5_flags_reg.zero <= p4_zero_reg;
        p5_flags_reg.full <= (p4_a_reg >= cfg.span);
        p5_meta_reg       <= p4_meta_reg;
        p6_num_reg        <= p5_m510_reg + {9'b0, cfg.span};
        p6_flags_reg      <= p5_flags_reg;
        p6_meta_reg       <= p5_meta_reg;
    end

    assign out_valid = p6_valid_reg;
    assign out_num   = p6_num_reg;
    assign out_meta  = p6_meta_reg;
    assign out_flags = p6_flags_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vwrgb_div.sv
`default_nettype none

module vwrgb_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [vwrgb_pkg::N_W-1:0]  in_num,
    input  vwrgb_pkg::meta_t           in_meta,
    input  vwrgb_pkg::map_flags_t      in_flags,
    input  vwrgb_pkg::cfg_t            cfg,
    output logic                       out_valid,
    output logic [7:0]                 out_quot,
    output vwrgb_pkg::meta_t           out_meta,
    output vwrgb_pkg::map_flags_t      out_flags
);
    import vwrgb_pkg::*;

    logic             valid_reg [DIV_STAGES];
    logic [N_W-1:0]   rem_reg   [DIV_STAGES];
    logic [7:0]       quot_reg  [DIV_STAGES];
    meta_t            meta_reg  [DIV_STAGES];
    map_flags_t       flags_reg [DIV_STAGES];

    logic [N_W-1:0]   dvsr;

    // divisor is 2*span
    assign dvsr = {{(N_W-Q_W-1){1'b0}}, cfg.span, 1'b0};

    // restoring division, one quotient bit per stage, msb first
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int BIT = DIV_STAGES - 1 - k;

        logic           valid_in;
        logic [N_W-1:0] rem_in;
        logic [7:0]     quot_in;
        meta_t          meta_in;
        map_flags_t     flags_in;
        logic [N_W:0]   diff;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_num;
            assign quot_in  = '0;
            assign meta_in  = in_meta;
            assign flags_in = in_flags;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign quot_in  = quot_reg[k-1];
            assign meta_in  = meta_reg[k-1];
            assign flags_in = flags_reg[k-1];
        end

        assign diff = {1'b0, rem_in} - {1'b0, dvsr << BIT};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (!diff[N_W])
            begin
                rem_reg[k]  <= diff[N_W-1:0];
                quot_reg[k] <= quot_in | (8'd1 << BIT);
            end
            else
            begin
                rem_reg[k]  <= rem_in;
                quot_reg[k] <= quot_in;
            end
            meta_reg[k]  <= meta_in;
            flags_reg[k] <= flags_in;
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot  = quot_reg[DIV_STAGES-1];
    assign out_meta  = meta_reg[DIV_STAGES-1];
    assign out_flags = flags_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/voxel_window_to_rgb8.sv
`default_nettype none

// Voxel to RGB byte converter.
// Input: one raw voxel per beat, taken at a clock edge with start high and
// busy low. A new voxel may follow in every cycle while busy is low.
// Output: done is high for exactly one cycle with the RGB beat on result;
// the receiver must take it then, there is no stall path. Results leave
// in input order, one per voxel.
// Pipeline: the voxel passes the input register, three conversion stages
// (decode, shift, sign), three window stages, eight restoring division
// stages (one quotient bit each) and the result register. Throughput is
// one voxel per cycle while busy is low.
// Configuration: write channel cfg_valid/cfg_ready with a register index;
// cfg_ready is always high. Write it only while no voxel is in flight.
// A write to either window bound raises busy for one cycle while the
// window span register updates.
// Reset: config registers return to defaults (uint8, window 0..255.0),
// the pipeline empties, and busy is high for the first cycle after reset.

module voxel_window_to_rgb8 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  vwrgb_pkg::in_item_t              item,
    output logic                             done,
    output vwrgb_pkg::out_item_t             result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vwrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vwrgb_pkg::Q_W-1:0]        cfg_data
);
    import vwrgb_pkg::*;

    cfg_t           cfg;

    logic           in_valid_reg;
    in_item_t       in_item_reg;

    logic           cv_valid;
    logic [Q_W-1:0] cv_value;
    meta_t          cv_meta;

    logic           wn_valid;
    logic [N_W-1:0] wn_num;
    meta_t          wn_meta;
    map_flags_t     wn_flags;

    logic           dv_valid;
    logic [7:0]     dv_quot;
    meta_t          dv_meta;
    map_flags_t     dv_flags;

    logic [7:0]     gray;
    out_item_t      result_next;
    out_item_t      result_reg;
    logic           done_reg;

    vwrgb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= item;
    end

    vwrgb_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .cfg       (cfg),
        .out_valid (cv_valid),
        .out_value (cv_value),
        .out_meta  (cv_meta)
    );

    vwrgb_win u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv_valid),
        .in_value  (cv_value),
        .in_meta   (cv_meta),
        .cfg       (cfg),
        .out_valid (wn_valid),
        .out_num   (wn_num),
        .out_meta  (wn_meta),
        .out_flags (wn_flags)
    );

    vwrgb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wn_valid),
        .in_num    (wn_num),
        .in_meta   (wn_meta),
        .in_flags  (wn_flags),
        .cfg       (cfg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_meta  (dv_meta),
        .out_flags (dv_flags)
    );

    always_comb
    begin
        if (dv_meta.bypass)
        begin
            gray = dv_meta.b0;
        end
        else if (dv_flags.zero)
        begin
            gray = '0;
        end
        else if (dv_flags.full)
        begin
            gray = GRAY_MAX;
        end
        else
        begin
            gray = dv_quot;
        end

        result_next.red_byte      = '0;
        result_next.green_byte    = '0;
        result_next.blue_byte     = '0;
        result_next.channel_valid = 3'b000;
        result_next.type_error    = dv_meta.err;
        result_next.slice_done    = dv_meta.eos;
        if (dv_meta.err)
        begin
            result_next.channel_valid = 3'b000;
        end
        else if (cfg.planar_color)
        begin
            case (cfg.plane_channel)
                CH_RED:
                begin
                    result_next.red_byte      = gray;
                    result_next.channel_valid = 3'b001;
                end
                CH_GREEN:
                begin
                    result_next.green_byte    = gray;
                    result_next.channel_valid = 3'b010;
                end
                CH_BLUE:
                begin
                    result_next.blue_byte     = gray;
                    result_next.channel_valid = 3'b100;
                end
                default: result_next.channel_valid = 3'b000;
            endcase
        end
        else if (dv_meta.is_rgb)
        begin
            result_next.red_byte      = dv_meta.b0;
            result_next.green_byte    = dv_meta.b1;
            result_next.blue_byte     = dv_meta.b2;
            result_next.channel_valid = 3'b111;
        end
        else
        begin
            result_next.red_byte      = gray;
            result_next.green_byte    = gray;
            result_next.blue_byte     = gray;
            result_next.channel_valid = 3'b111;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
